// ===== rtl/ctkd_pkg.sv =====
// Shared types, constants and register codes of the touch key detector.
package ctkd_pkg;

    localparam int SAMPLE_W      = 16;
    localparam int CALIB_SAMPLES = 10;
    localparam int CAL_CNT_W     = $clog2(CALIB_SAMPLES + 1);
    localparam int MID_LO        = 2;
    localparam int MID_HI        = 8;
    localparam int MID_COUNT     = MID_HI - MID_LO;
    localparam int SUM_W         = SAMPLE_W + $clog2(MID_COUNT);
    // floor(s / 6) == (s * RECIP_SIX) >> RECIP_SHIFT for every s below 2**19
    localparam int RECIP_W       = 18;
    localparam int RECIP_SHIFT   = 20;
    localparam logic [RECIP_W-1:0] RECIP_SIX = 18'd174763;
    localparam int PROD_W        = SUM_W + RECIP_W;

    localparam int GRP_W         = 3;
    localparam logic [GRP_W-1:0] SINGLE_GROUP = 3'd3;
    localparam logic [GRP_W-1:0] CONT_GROUP   = 3'd6;
    localparam logic [1:0] LOCKOUT_AFTER_TOUCH = 2'd2;  // reload of 3, less this group

    localparam logic [SAMPLE_W-1:0] GATE_RESET = 16'd20;

    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_CONT_MODE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_GATE      = 1'b1;

    localparam logic KIND_CALIB = 1'b0;
    localparam logic KIND_SCAN  = 1'b1;

    typedef logic [SAMPLE_W-1:0] sample_t;

    typedef struct packed {
        logic    kind;
        logic    pressed;
        logic    err;
        sample_t baseline;
        sample_t peak;
    } result_t;

endpackage

// ===== rtl/ctkd_sort_cell.sv =====
// One cell of the insertion-sort chain that orders the calibration samples.
module ctkd_sort_cell (
    input  logic             clk,
    input  logic             ins,
    input  ctkd_pkg::sample_t x,
    input  logic             occupied,
    input  ctkd_pkg::sample_t left_val,
    input  logic             left_gt,
    output ctkd_pkg::sample_t val,
    output logic             gt
);
    import ctkd_pkg::*;

    sample_t val_reg;
    sample_t val_next;

    // An empty cell acts as +infinity so the new sample lands in the first free slot.
    assign gt = !occupied || (val_reg > x);
    assign val = val_reg;

    always_comb
    begin
        val_next = val_reg;
        if (ins && gt)
        begin
            // shift the left neighbor in, or take the sample at the insert point
            val_next = left_gt ? left_val : x;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
    end

endmodule

// ===== rtl/ctkd_scan.sv =====
// Group peak tracking, touch decision and press lockout for scan samples.
module ctkd_scan (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              take,
    input  ctkd_pkg::sample_t x,
    input  logic              cont_mode,
    input  ctkd_pkg::sample_t gate,
    input  ctkd_pkg::sample_t baseline,
    output logic              close,
    output ctkd_pkg::result_t res
);
    import ctkd_pkg::*;

    logic [GRP_W-1:0]      group_count_reg;
    logic [GRP_W-1:0]      group_count_next;
    sample_t               running_peak_reg;
    sample_t               running_peak_next;
    logic [1:0]            lockout_reg;
    logic [1:0]            lockout_next;

    sample_t               peak;
    logic [GRP_W-1:0]      count_inc;
    logic [GRP_W-1:0]      group_size;
    logic [SAMPLE_W:0]     lower_bound;
    logic [SAMPLE_W+3:0]   upper_bound;
    logic                  touched;
    logic [1:0]            lock_eff;

    assign peak        = (x > running_peak_reg) ? x : running_peak_reg;
    assign count_inc   = group_count_reg + 1'b1;
    assign group_size  = cont_mode ? CONT_GROUP : SINGLE_GROUP;
    assign close       = take && (count_inc >= group_size);
    assign lower_bound = {1'b0, baseline} + {1'b0, gate};
    assign upper_bound = {1'b0, baseline, 3'b000} + {3'b000, baseline, 1'b0};
    assign touched     = ({1'b0, peak} > lower_bound) && ({4'b0000, peak} < upper_bound);
    assign lock_eff    = cont_mode ? 2'd0 : lockout_reg;

    always_comb
    begin
        res.kind     = KIND_SCAN;
        res.pressed  = touched && (lock_eff == 2'd0);
        res.err      = baseline[SAMPLE_W-1];
        res.baseline = baseline;
        res.peak     = peak;
    end

    always_comb
    begin
        group_count_next  = group_count_reg;
        running_peak_next = running_peak_reg;
        lockout_next      = lockout_reg;
        if (take)
        begin
            if (close)
            begin
                group_count_next  = '0;
                running_peak_next = '0;
                if (touched)
                    lockout_next = LOCKOUT_AFTER_TOUCH;
                else if (lock_eff != 2'd0)
                    lockout_next = lock_eff - 1'b1;
                else
                    lockout_next = 2'd0;
            end
            else
            begin
                group_count_next  = count_inc;
                running_peak_next = peak;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            group_count_reg  <= '0;
            running_peak_reg <= '0;
            lockout_reg      <= '0;
        end
        else
        begin
            group_count_reg  <= group_count_next;
            running_peak_reg <= running_peak_next;
            lockout_reg      <= lockout_next;
        end
    end

endmodule

// ===== rtl/ctkd_res_fifo.sv =====
// Two-entry result buffer between the detector and the output channel.
module ctkd_res_fifo (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  ctkd_pkg::result_t push_data,
    input  logic              pop,
    output logic              not_empty,
    output logic [1:0]        count,
    output ctkd_pkg::result_t head
);
    import ctkd_pkg::*;

    result_t    entry_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;

    assign not_empty = (count_reg != 2'd0);
    assign count     = count_reg;
    assign head      = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop  ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== rtl/capacitive_touch_key_detector_top.sv =====
// Top level of the capacitive touch key detector.
//
//   channel  | handshake           | payload
//   ---------+---------------------+-------------------------------------------------
//   input    | in_valid / in_stall | charge_time
//   result   | out_valid/out_stall | result_kind, pressed, calib_error,
//            |                     | baseline_value, group_peak
//   config   | cfg_write           | cfg_index, cfg_data
//
// One sample is taken per cycle while in_stall is low. A scan result is pushed at the edge
// that takes the group's closing sample; the calibration result follows the tenth sample
// via a registered sum of the middle six sorted cells and a reciprocal multiply by one sixth.
// Reset clears counters, baseline, lockout and the result buffer; the sort cells are
// filled by calibration. in_stall rises only when the two-entry result buffer plus a
// calibration result still in flight would fill, so output stalls back up after two items.
module capacitive_touch_key_detector_top (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [15:0]                    charge_time,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic                           result_kind,
    output logic                           pressed,
    output logic                           calib_error,
    output logic [15:0]                    baseline_value,
    output logic [15:0]                    group_peak,
    input  logic                           cfg_write,
    input  logic [ctkd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [15:0]                    cfg_data
);
    import ctkd_pkg::*;

    logic                 cont_mode_reg;
    logic                 cont_mode_next;
    sample_t              gate_reg;
    sample_t              gate_next;
    logic [CAL_CNT_W-1:0] calib_count_reg;
    logic [CAL_CNT_W-1:0] calib_count_next;
    logic                 calibrated_reg;
    logic                 calibrated_next;
    logic                 sum_pend_reg;
    logic                 sum_pend_next;
    logic                 div_pend_reg;
    logic                 div_pend_next;
    logic [SUM_W-1:0]     sum_reg;
    logic [SUM_W-1:0]     sum_next;
    sample_t              baseline_reg;
    sample_t              baseline_next;

    logic                 accept;
    logic                 cal_take;
    logic                 scan_take;
    sample_t              cell_val [CALIB_SAMPLES];
    logic                 cell_gt  [CALIB_SAMPLES];
    logic [PROD_W-1:0]    prod;
    sample_t              quot;
    logic                 scan_close;
    result_t              scan_res;
    result_t              cal_res;
    result_t              push_data;
    logic                 push;
    logic                 pop;
    logic                 buf_not_empty;
    logic [1:0]           buf_count;
    result_t              head;
    logic [1:0]           occupancy;

    // Reserve room for the calibration result while it is still being computed.
    assign occupancy = buf_count + {1'b0, sum_pend_reg | div_pend_reg};
    assign in_stall  = (occupancy >= 2'd2);
    assign accept    = in_valid && !in_stall;
    assign cal_take  = accept && !calibrated_reg;
    assign scan_take = accept && calibrated_reg;

    // Insertion chain: each cell compares against the sample and hands its value right.
    for (genvar i = 0; i < CALIB_SAMPLES; i++)
    begin : g_cell
        ctkd_sort_cell u_cell (
            .clk      (clk),
            .ins      (cal_take),
            .x        (charge_time),
            .occupied (calib_count_reg > CAL_CNT_W'(i)),
            .left_val ((i == 0) ? sample_t'(0) : cell_val[(i == 0) ? 0 : i - 1]),
            .left_gt  ((i == 0) ? 1'b0 : cell_gt[(i == 0) ? 0 : i - 1]),
            .val      (cell_val[i]),
            .gt       (cell_gt[i])
        );
    end

    // Sum the middle six sorted cells.
    always_comb
    begin
        sum_next = sum_reg;
        if (sum_pend_reg)
        begin
            sum_next = '0;
            for (int k = MID_LO; k < MID_HI; k++)
                sum_next = sum_next + SUM_W'(cell_val[k]);
        end
    end

    // Divide by six through the reciprocal.
    assign prod = PROD_W'(sum_reg) * PROD_W'(RECIP_SIX);
    assign quot = prod[RECIP_SHIFT +: SAMPLE_W];

    always_comb
    begin
        cal_res.kind     = KIND_CALIB;
        cal_res.pressed  = 1'b0;
        cal_res.err      = quot[SAMPLE_W-1];
        cal_res.baseline = quot;
        cal_res.peak     = '0;
    end

    ctkd_scan u_scan (
        .clk       (clk),
        .rst_n     (rst_n),
        .take      (scan_take),
        .x         (charge_time),
        .cont_mode (cont_mode_reg),
        .gate      (gate_reg),
        .baseline  (baseline_reg),
        .close     (scan_close),
        .res       (scan_res)
    );

    // A scan group closes three samples after calibration at the earliest, so the two
    // push sources never coincide.
    assign push      = div_pend_reg || scan_close;
    assign push_data = div_pend_reg ? cal_res : scan_res;
    assign pop       = buf_not_empty && !out_stall;

    ctkd_res_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .not_empty (buf_not_empty),
        .count     (buf_count),
        .head      (head)
    );

    assign out_valid      = buf_not_empty;
    assign result_kind    = head.kind;
    assign pressed        = head.pressed;
    assign calib_error    = head.err;
    assign baseline_value = head.baseline;
    assign group_peak     = head.peak;

    always_comb
    begin
        cont_mode_next   = cont_mode_reg;
        gate_next        = gate_reg;
        calib_count_next = calib_count_reg;
        calibrated_next  = calibrated_reg;
        sum_pend_next    = 1'b0;
        div_pend_next    = sum_pend_reg;
        baseline_next    = div_pend_reg ? quot : baseline_reg;

        if (cfg_write)
        begin
            case (cfg_index)
                CFG_CONT_MODE: cont_mode_next = cfg_data[0];
                CFG_GATE:      gate_next      = cfg_data;
                default:       gate_next      = gate_reg;
            endcase
        end

        if (cal_take)
        begin
            if (calib_count_reg == CAL_CNT_W'(CALIB_SAMPLES - 1))
            begin
                // last calibration sample: start the baseline pipeline
                calib_count_next = '0;
                calibrated_next  = 1'b1;
                sum_pend_next    = 1'b1;
            end
            else
            begin
                calib_count_next = calib_count_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        sum_reg <= sum_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cont_mode_reg   <= 1'b0;
            gate_reg        <= GATE_RESET;
            calib_count_reg <= '0;
            calibrated_reg  <= 1'b0;
            sum_pend_reg    <= 1'b0;
            div_pend_reg    <= 1'b0;
            baseline_reg    <= '0;
        end
        else
        begin
            cont_mode_reg   <= cont_mode_next;
            gate_reg        <= gate_next;
            calib_count_reg <= calib_count_next;
            calibrated_reg  <= calibrated_next;
            sum_pend_reg    <= sum_pend_next;
            div_pend_reg    <= div_pend_next;
            baseline_reg    <= baseline_next;
        end
    end

endmodule

// ===== sim/ctkd_checker.sv =====
// Scoreboard for the touch key detector: predicts each result item and compares it.
`timescale 1ns / 100ps

module ctkd_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    input  logic                           in_stall,
    input  logic [15:0]                    charge_time,
    input  logic                           out_valid,
    input  logic                           out_stall,
    input  logic                           result_kind,
    input  logic                           pressed,
    input  logic                           calib_error,
    input  logic [15:0]                    baseline_value,
    input  logic [15:0]                    group_peak,
    input  logic                           cfg_write,
    input  logic [ctkd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [15:0]                    cfg_data,
    output int                             mismatches,
    output int                             outstanding
);
    import ctkd_pkg::*;

    localparam logic [1:0] LOCK_RELOAD  = 2'd3;
    localparam int         UPPER_FACTOR = 10;
    localparam sample_t    HALF_SCALE   = 16'h7FFF;
    localparam int         REPORT_LIMIT = 10;

    // predictor state
    sample_t          cal_buf [CALIB_SAMPLES];
    int               cal_cnt;
    bit               have_baseline;
    sample_t          base_val;
    logic [GRP_W-1:0] grp_cnt;
    sample_t          peak_acc;
    logic [1:0]       lock_cnt;

    // register copies
    logic             cont_mode;
    sample_t          gate_cfg;

    result_t          expected_q [$];
    int               bad_cnt = 0;

    assign mismatches = bad_cnt;

    // sort the calibration samples, then average the middle six
    function automatic sample_t trimmed_mean();
        sample_t s [CALIB_SAMPLES];
        sample_t t;
        int      sum;
        s = cal_buf;
        for (int i = 0; i < CALIB_SAMPLES - 1; i++)
        begin
            for (int j = 0; j < CALIB_SAMPLES - 1 - i; j++)
            begin
                if (s[j] > s[j + 1])
                begin
                    t        = s[j];
                    s[j]     = s[j + 1];
                    s[j + 1] = t;
                end
            end
        end
        sum = 0;
        for (int i = MID_LO; i < MID_HI; i++)
            sum += s[i];
        return sample_t'(sum / MID_COUNT);
    endfunction

    task automatic flag(string what, int want_v, int got_v);
        bad_cnt++;
        if (bad_cnt <= REPORT_LIMIT)
            $display("mismatch at %0t: %s expected %0d, got %0d", $time, what, want_v, got_v);
    endtask

    task automatic take_sample(sample_t x);
        result_t r;
        int      lower;
        int      upper;
        logic    touched;
        if (!have_baseline)
        begin
            cal_buf[cal_cnt] = x;
            cal_cnt++;
            if (cal_cnt < CALIB_SAMPLES)
                return;
            cal_cnt       = 0;
            have_baseline = 1'b1;
            base_val      = trimmed_mean();
            r.kind        = KIND_CALIB;
            r.pressed     = 1'b0;
            r.err         = base_val > HALF_SCALE;
            r.baseline    = base_val;
            r.peak        = '0;
            expected_q.push_back(r);
            return;
        end
        if (x > peak_acc)
            peak_acc = x;
        grp_cnt = grp_cnt + 1'b1;
        if (grp_cnt < (cont_mode ? CONT_GROUP : SINGLE_GROUP))
            return;
        // both bounds at full width, so no wrap above 16 bits
        lower   = int'(base_val) + int'(gate_cfg);
        upper   = UPPER_FACTOR * int'(base_val);
        touched = (int'(peak_acc) > lower) && (int'(peak_acc) < upper);
        r.kind    = KIND_SCAN;
        r.pressed = 1'b0;
        if (cont_mode)
            lock_cnt = '0;
        if (touched)
        begin
            r.pressed = (lock_cnt == 0);
            lock_cnt  = LOCK_RELOAD;
        end
        if (lock_cnt != 0)
            lock_cnt--;
        r.err      = base_val > HALF_SCALE;
        r.baseline = base_val;
        r.peak     = peak_acc;
        grp_cnt    = '0;
        peak_acc   = '0;
        expected_q.push_back(r);
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        result_t want;
        if (!rst_n)
        begin
            cal_cnt       = 0;
            have_baseline = 1'b0;
            base_val      = '0;
            grp_cnt       = '0;
            peak_acc      = '0;
            lock_cnt      = '0;
            cont_mode     = 1'b0;
            gate_cfg      = GATE_RESET;
            expected_q.delete();
            outstanding  <= 0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    CFG_CONT_MODE: cont_mode = cfg_data[0];
                    CFG_GATE:      gate_cfg  = cfg_data;
                    default:       ;
                endcase
            end
            // results leave a register, so drain them before the new sample
            if (out_valid && !out_stall)
            begin
                if (expected_q.size() == 0)
                    flag("result items pending", 0, 1);
                else
                begin
                    want = expected_q.pop_front();
                    if (result_kind !== want.kind)
                        flag("result_kind", want.kind, result_kind);
                    if (pressed !== want.pressed)
                        flag("pressed", want.pressed, pressed);
                    if (calib_error !== want.err)
                        flag("calib_error", want.err, calib_error);
                    if (baseline_value !== want.baseline)
                        flag("baseline_value", want.baseline, baseline_value);
                    if (group_peak !== want.peak)
                        flag("group_peak", want.peak, group_peak);
                end
            end
            if (in_valid && !in_stall)
                take_sample(charge_time);
            outstanding <= expected_q.size();
        end
    end

endmodule

// ===== sim/capacitive_touch_key_detector_top_tb.sv =====
// Testbench top for the touch key detector: stimulus, stalls, watchdog and verdict.
`timescale 1ns / 100ps

module capacitive_touch_key_detector_top_tb;
    import ctkd_pkg::*;

    localparam int      RESET_CYCLES   = 7;
    // calibration result lags its last sample; leave margin for it
    localparam int      SETTLE_CYCLES  = 4;
    localparam int      END_CYCLES     = 8;
    localparam int      WATCHDOG_LIMIT = 5000;
    localparam int      UPPER_FACTOR   = 10;
    localparam sample_t SAMPLE_MAX     = 16'hFFFF;

    // shape of one scan group in the random part
    typedef enum int {GRP_QUIET, GRP_TOUCH, GRP_EDGE, GRP_NOISE} group_kind_t;

    logic                 clk;
    logic                 rst_n          = 1'b0;
    logic                 in_valid       = 1'b0;
    logic                 in_stall;
    logic [15:0]          charge_time    = '0;
    logic                 out_valid;
    logic                 out_stall      = 1'b0;
    logic                 result_kind;
    logic                 pressed;
    logic                 calib_error;
    logic [15:0]          baseline_value;
    logic [15:0]          group_peak;
    logic                 cfg_write      = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index      = CFG_CONT_MODE;
    logic [15:0]          cfg_data       = '0;

    int                   mismatches;
    int                   outstanding;

    // stimulus knobs and what the stimulus knows of the block
    int                   send_idle_pct  = 0;
    int                   recv_stall_pct = 0;
    logic                 mode_now       = 1'b0;
    sample_t              gate_now       = GATE_RESET;
    sample_t              seen_baseline  = '0;
    int                   idle_cycles    = 0;

    capacitive_touch_key_detector_top dut (.*);

    ctkd_checker scoreboard (.*);

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Receiver side: stall at random, one decision per cycle.
    always @(posedge clk)
        out_stall <= ($urandom_range(0, 99) < recv_stall_pct);

    // Keep the calibrated baseline so the scan samples can be aimed at the thresholds.
    always @(posedge clk)
    begin
        if (out_valid && !out_stall && result_kind == KIND_CALIB)
            seen_baseline <= baseline_value;
    end

    // Watchdog: give up when no handshake of any kind happens for too long.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_write)
                idle_cycles <= 0;
            else if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("watchdog: no handshake for %0d cycles", idle_cycles);
                $display("TEST FAILED");
                $finish;
            end
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    function automatic sample_t clamp16(int v);
        if (v < 0)
            return '0;
        if (v > int'(SAMPLE_MAX))
            return SAMPLE_MAX;
        return sample_t'(v);
    endfunction

    // Offer one item, idling first at random; return at the edge that takes it.
    task automatic send_sample(sample_t v);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        charge_time <= v;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    // Drop valid and hold until every predicted result item has come back,
    // then let the pipeline settle in case a calibration is still in flight.
    task automatic wait_idle();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (outstanding != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Write one register, only ever with the block idle.
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, sample_t val);
        wait_idle();
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_write <= 1'b0;
        if (idx == CFG_CONT_MODE)
            mode_now = val[0];
        else
            gate_now = val;
    endtask

    // Pick one scan sample for a group of the given shape. The hot sample is
    // the one meant to carry the group maximum.
    function automatic sample_t pick_sample(group_kind_t kind, bit hot);
        int lo;
        int hi;
        int v;
        lo = int'(seen_baseline) + int'(gate_now);
        hi = UPPER_FACTOR * int'(seen_baseline);
        case (kind)
            GRP_QUIET:
                v = $urandom_range(0, clamp16(lo));
            GRP_TOUCH:
            begin
                if (hot && lo + 1 < hi && lo < int'(SAMPLE_MAX))
                    v = $urandom_range(lo + 1, clamp16(hi - 1));
                else
                    v = $urandom_range(0, clamp16(lo));
            end
            GRP_EDGE:
            begin
                // both sides of both bounds, and the ends of the range
                case ($urandom_range(0, 7))
                    0:       v = lo - 1;
                    1:       v = lo;
                    2:       v = lo + 1;
                    3:       v = hi - 1;
                    4:       v = hi;
                    5:       v = hi + 1;
                    6:       v = 0;
                    default: v = int'(SAMPLE_MAX);
                endcase
            end
            default:
                v = $urandom_range(0, int'(SAMPLE_MAX));
        endcase
        return clamp16(v);
    endfunction

    // Ten calibration samples around a random center, with a zero and a full-scale
    // outlier that the trimmed mean must throw away. The center picks one of three
    // cases: zero baseline, baseline above half scale (error), or a normal pad.
    task automatic calibrate();
        sample_t cal [CALIB_SAMPLES];
        int      center;
        int      spread;
        int      flavor;
        int      lo_pos;
        int      hi_pos;
        flavor = $urandom_range(0, 7);
        if (flavor == 0)
        begin
            center = 0;
            spread = 0;
        end
        else if (flavor <= 2)
        begin
            center = $urandom_range(33000, 60000);
            spread = (int'(SAMPLE_MAX) - center) / 4;
        end
        else
        begin
            center = $urandom_range(20, 3000);
            spread = center / 4;
        end
        for (int i = 0; i < CALIB_SAMPLES; i++)
            cal[i] = clamp16(center + $urandom_range(0, spread));
        lo_pos = $urandom_range(0, CALIB_SAMPLES - 1);
        hi_pos = (lo_pos + $urandom_range(1, CALIB_SAMPLES - 1)) % CALIB_SAMPLES;
        cal[lo_pos] = '0;
        cal[hi_pos] = SAMPLE_MAX;
        for (int i = 0; i < CALIB_SAMPLES; i++)
            send_sample(cal[i]);
    endtask

    // Five single-mode groups around the touch bounds and the lockout.
    task automatic directed_scan();
        int lo;
        int hi;
        lo = int'(seen_baseline) + int'(gate_now);
        hi = UPPER_FACTOR * int'(seen_baseline);
        // maximum just above the gate: first press
        send_sample(seen_baseline);
        send_sample('0);
        send_sample(clamp16(lo + 1));
        // touch again right away: held off by the lockout
        send_sample(clamp16(lo + 1));
        send_sample(seen_baseline);
        send_sample('0);
        // maximum equal to the gate: no touch
        send_sample(clamp16(lo));
        send_sample(seen_baseline);
        send_sample('0);
        // full scale and the upper bound itself
        send_sample(SAMPLE_MAX);
        send_sample(clamp16(hi));
        send_sample(16'd1);
        // just under the upper bound once the lockout has run down
        send_sample(clamp16(hi - 1));
        send_sample('0);
        send_sample(seen_baseline);
    endtask

    // Random groups sized by the current mode, with random shapes so that touched
    // groups land 0, 1, 2 or more groups apart and walk the lockout through its states.
    task automatic random_segment(int count);
        int          sent;
        int          gsz;
        int          hot;
        int          r;
        group_kind_t kind;
        sent = 0;
        while (sent < count)
        begin
            gsz  = mode_now ? int'(CONT_GROUP) : int'(SINGLE_GROUP);
            hot  = $urandom_range(0, gsz - 1);
            r    = $urandom_range(0, 9);
            kind = (r < 4) ? GRP_QUIET : (r < 7) ? GRP_TOUCH : (r < 9) ? GRP_EDGE : GRP_NOISE;
            for (int j = 0; j < gsz && sent < count; j++)
            begin
                send_sample(pick_sample(kind, j == hot));
                sent++;
            end
        end
    endtask

    initial
    begin : stimulus
        int      seg;
        sample_t gate_pick;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        send_idle_pct  = 11;
        recv_stall_pct <= 63;
        write_reg(CFG_CONT_MODE, 16'd0);
        write_reg(CFG_GATE, GATE_RESET);

        calibrate();
        // hold until the baseline is back, so the scan can be aimed at it
        wait_idle();
        directed_scan();

        // Three idling schemes, two register settings each. The mode flips between
        // segments, so a partly filled group often sees its size change.
        for (int phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0:
                begin
                    send_idle_pct  = 11;
                    recv_stall_pct <= 63;
                end
                1:
                begin
                    send_idle_pct  = 63;
                    recv_stall_pct <= 11;
                end
                default:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct <= 0;
                end
            endcase
            for (int k = 0; k < 2; k++)
            begin
                seg = phase * 2 + k;
                case (seg)
                    0:       gate_pick = '0;
                    1:       gate_pick = SAMPLE_MAX;
                    2:       gate_pick = sample_t'($urandom_range(0, 255));
                    3:       gate_pick = sample_t'($urandom_range(0, 4095));
                    4:       gate_pick = sample_t'($urandom_range(0, int'(SAMPLE_MAX)));
                    default: gate_pick = GATE_RESET;
                endcase
                write_reg(CFG_CONT_MODE, (seg % 2 == 0) ? 16'd1 : 16'd0);
                write_reg(CFG_GATE, gate_pick);
                random_segment($urandom_range(70, 95));
            end
        end

        // drain, then watch a little longer for stray result items
        wait_idle();
        repeat (END_CYCLES) @(posedge clk);
        if (mismatches == 0 && outstanding == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/ctkd_pkg.sv
rtl/ctkd_sort_cell.sv
rtl/ctkd_scan.sv
rtl/ctkd_res_fifo.sv
rtl/capacitive_touch_key_detector_top.sv
sim/ctkd_checker.sv
sim/capacitive_touch_key_detector_top_tb.sv
